/* rtl/core/ais_pkg.sv */
// Package for the argsort index sorter: field widths, cell payload and control types,
// and the controller state encoding. Depends on nothing.
`default_nettype none

package ais_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 6;

    typedef logic signed [VALUE_W-1:0] key_t;
    typedef logic        [POS_W-1:0]   pos_t;

    // One stored entry: the value and its arrival index.
    typedef struct packed {
        key_t key;
        pos_t pos;
    } entry_t;

    // Broadcast control from the controller to every cell.
    typedef struct packed {
        logic insert;   // place the broadcast entry, shift greater entries up
        logic drain;    // shift every entry down by one cell
    } cell_ctrl_t;

    typedef enum logic [0:0] {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } ctrl_state_t;

endpackage

`default_nettype wire

/* rtl/core/argsort_index_sorter_unit.sv */
// Top level of the argsort index sorter: stream ports, load/drain controller and
// the chain of ais_cell instances. Depends on ais_pkg and ais_cell.
//
//   channel  dir  tdata                        tlast         tuser
//   s_       in   [31:0] value (Q16.16)        final_value   -
//   m_       out  [5:0] position, [7:6] zero   final_result  [0] overflowed
//
// Loading takes one beat per cycle: every cell compares against the new value at
// once, so insertion does not depend on how many values are held.
// After the final beat the chain drains from cell 0, one result beat per cycle
// while m_tready is high.
// s_tready stays low while draining; a stall on m_tready holds the chain.
// aresetn (synchronous) clears the count, overflow flag and controller only.
`default_nettype none

module argsort_index_sorter_unit #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,   // final_value
    // result beats
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // [5:0] position, [7:6] zero
    output      logic        m_tlast,   // final_result
    output      logic [0:0]  m_tuser    // [0] overflowed
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    ais_pkg::ctrl_state_t state_reg;
    ais_pkg::ctrl_state_t state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 overflow_reg;
    logic                 overflow_next;

    logic                 in_beat;
    logic                 out_beat;
    logic                 full;
    ais_pkg::cell_ctrl_t  ctrl;
    ais_pkg::entry_t      new_entry;

    ais_pkg::entry_t      entries [MAX_ITEMS];
    logic                 gts     [MAX_ITEMS];
    logic                 occ     [MAX_ITEMS];

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;
    assign full     = (count_reg == CNT_W'(MAX_ITEMS));

    assign new_entry.key = s_tdata;
    assign new_entry.pos = ais_pkg::POS_W'(count_reg);

    // Insert only while room is left; a beat into a full chain just flags overflow.
    assign ctrl.insert = in_beat && !full;
    assign ctrl.drain  = out_beat;

    // ---------------------------------------------------------------- cell chain
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic            prev_occupied;
        logic            prev_gt;
        ais_pkg::entry_t prev_entry;
        ais_pkg::entry_t next_entry;

        assign occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign prev_occupied = 1'b1;
            assign prev_gt       = 1'b0;
            assign prev_entry    = new_entry;
        end else begin : g_rest
            assign prev_occupied = occ[i-1];
            assign prev_gt       = gts[i-1];
            assign prev_entry    = entries[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_top
            // Nothing above the top cell; what shifts in is never read.
            assign next_entry = new_entry;
        end else begin : g_mid
            assign next_entry = entries[i+1];
        end

        ais_cell u_cell (
            .aclk          (aclk),
            .ctrl          (ctrl),
            .new_entry     (new_entry),
            .occupied      (occ[i]),
            .prev_occupied (prev_occupied),
            .prev_gt       (prev_gt),
            .prev_entry    (prev_entry),
            .next_entry    (next_entry),
            .entry         (entries[i]),
            .gt            (gts[i])
        );
    end

    // ---------------------------------------------------------------- controller
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        unique case (state_reg)
            ais_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (in_beat) begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    // Switch to draining after the final beat; count is at least one.
                    if (s_tlast) begin
                        state_next = ais_pkg::ST_DRAIN;
                    end
                end
            end
            ais_pkg::ST_DRAIN: begin
                m_tvalid = 1'b1;
                if (out_beat) begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        overflow_next = 1'b0;
                        state_next    = ais_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ais_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ais_pkg::ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // Results come straight out of cell 0.
    assign m_tdata = {2'b00, entries[0].pos};
    assign m_tlast = (count_reg == CNT_W'(1));
    assign m_tuser = overflow_reg;

    // ---------------------------------------------------------------- checks
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open at once");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("count beyond chain length");

    a_drain_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && count_reg != '0))
        else $error("final beat did not start a nonempty drain");

    a_drain_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && count_reg == '0 && !overflow_reg))
        else $error("drain did not return to an empty set");

    // While loading, overflow can only be flagged once the chain is full.
    a_no_overflow_early: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (full || state_reg == ais_pkg::ST_DRAIN))
        else $error("overflow flagged with room left");

endmodule

`default_nettype wire

/* rtl/core/ais_cell.sv */
// One cell of the insertion chain: holds one entry and hands it up or down.
// Depends on ais_pkg.
`default_nettype none

module ais_cell (
    input  wire logic                aclk,
    input  wire ais_pkg::cell_ctrl_t ctrl,
    input  wire ais_pkg::entry_t     new_entry,     // broadcast entry to insert
    input  wire logic                occupied,      // this cell holds a live entry
    input  wire logic                prev_occupied, // lower neighbor is live
    input  wire logic                prev_gt,       // lower neighbor is greater
    input  wire ais_pkg::entry_t     prev_entry,
    input  wire ais_pkg::entry_t     next_entry,
    output      ais_pkg::entry_t     entry,
    output      logic                gt
);

    ais_pkg::entry_t entry_reg;
    ais_pkg::entry_t entry_next;

    // Strictly greater only, so equal values keep arrival order.
    assign gt    = occupied && (entry_reg.key > new_entry.key);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert && (gt || !occupied)) begin
            if (prev_gt) begin
                entry_next = prev_entry;
            end else if (prev_occupied) begin
                entry_next = new_entry;
            end
        end else if (ctrl.drain) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for argsort_index_sorter_unit: a queued stream driver, a result
// monitor and an in-bench stable argsort predictor. Depends on ais_pkg and the RTL top.
`default_nettype none

module tb;

    localparam int CAPACITY     = 64;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int SETTLE_TAIL  = 80;    // longer than one full drain
    localparam int RANDOM_ITEMS = 330;
    localparam int CALM_TAIL    = 30;    // no idling once this few input beats remain

    typedef struct {
        ais_pkg::key_t value;
        logic last;
        bit   wait_drain;  // hold this beat back until every result has come
    } value_beat_t;

    typedef struct {
        ais_pkg::pos_t position;
        logic final_result;
        logic overflowed;
    } order_beat_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [31:0] s_tdata = '0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    value_beat_t pending[$];
    order_beat_t order_due[$];

    // predictor state: held values in ascending order with their arrival indices
    ais_pkg::key_t held_key[CAPACITY];
    ais_pkg::pos_t held_pos[CAPACITY];
    int   held_count   = 0;
    bit   held_dropped = 1'b0;

    int beats_in    = 0;
    int beats_out   = 0;
    int mismatches  = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;
    value_beat_t next_beat;
    order_beat_t want;

    always #6 aclk = ~aclk;

    argsort_index_sorter_unit #(
        .MAX_ITEMS(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // Insert one accepted value; on the last value of a set, queue the sorted indices.
    function automatic void sort_in(ais_pkg::key_t v, logic last);
        int slot;
        order_beat_t ob;
        if (held_count < CAPACITY) begin
            slot = held_count;
            // equal values stay below the newcomer, so ties keep arrival order
            while (slot > 0 && held_key[slot-1] > v) begin
                held_key[slot] = held_key[slot-1];
                held_pos[slot] = held_pos[slot-1];
                slot--;
            end
            held_key[slot] = v;
            held_pos[slot] = ais_pkg::pos_t'(held_count);
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < held_count; k++) begin
                ob.position     = held_pos[k];
                ob.final_result = (k == held_count - 1);
                ob.overflowed   = held_dropped;
                order_due.insert(order_due.size(), ob);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endfunction

    // Draw a value: full range, a narrow band that forces ties, or mostly extremes.
    function automatic ais_pkg::key_t pick_value(int mode);
        ais_pkg::key_t v;
        case (mode)
            0: v = ais_pkg::key_t'($urandom);
            1: v = ais_pkg::key_t'($signed($urandom_range(0, 6)) - 3);
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = '0;
                    3: v = -32'sd1;
                    default: v = ais_pkg::key_t'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_beat(ais_pkg::key_t v, logic last, bit wait_drain);
        value_beat_t b;
        b.value      = v;
        b.last       = last;
        b.wait_drain = wait_drain;
        pending.insert(pending.size(), b);
    endtask

    task automatic add_set(int size, bit wait_drain);
        int mode;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < size; i++)
            add_beat(pick_value(mode), i == size - 1, wait_drain && i == 0);
    endtask

    // Driver: present the next queued beat, hold it until accepted, idle in bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sort_in(ais_pkg::key_t'(s_tdata), s_tlast);
                beats_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() != 0 &&
                             (!pending[0].wait_drain || order_due.size() == 0)) begin
                    if (pending.size() > CALM_TAIL && (beats_in % 60) < 40 &&
                        $urandom_range(0, 7) == 0) begin
                        // idle burst: drop valid now and draw a random gap length
                        gap_left = $urandom_range(0, 12);
                        s_tvalid <= 1'b0;
                    end else begin
                        next_beat = pending.pop_front();
                        s_tvalid <= 1'b1;
                        s_tdata  <= next_beat.value;
                        s_tlast  <= next_beat.last;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every accepted result beat against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (order_due.size() == 0) begin
                    $error("result beat with nothing expected: position %0d", m_tdata[5:0]);
                    mismatches++;
                end else begin
                    want = order_due.pop_front();
                    if (m_tdata[5:0] !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, m_tdata[5:0]);
                        mismatches++;
                    end
                    if (m_tlast !== want.final_result) begin
                        $error("final_result: expected %0b, got %0b",
                               want.final_result, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser[0] !== want.overflowed) begin
                        $error("overflowed: expected %0b, got %0b",
                               want.overflowed, m_tuser[0]);
                        mismatches++;
                    end
                end
            end
            // stall in bursts, except in calm windows and near the end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (pending.size() > CALM_TAIL && (beats_out % 50) < 35 &&
                         $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int queued;
        int size;

        // single-value set holding the largest value
        add_beat(32'sh7FFF_FFFF, 1'b1, 1'b0);
        // extremes around zero and both ends of the range
        add_beat(32'sh8000_0000, 1'b0, 1'b0);
        add_beat(32'sh7FFF_FFFF, 1'b0, 1'b0);
        add_beat(32'sh0000_0000, 1'b0, 1'b0);
        add_beat(-32'sd1,        1'b0, 1'b0);
        add_beat(32'sd1,         1'b0, 1'b0);
        add_beat(32'sh0001_0000, 1'b0, 1'b0);
        add_beat(-32'sh0001_0000, 1'b1, 1'b0);
        // ties keep arrival order; wait for the previous run to drain first
        add_beat(32'sd3,  1'b0, 1'b1);
        add_beat(32'sd3,  1'b0, 1'b0);
        add_beat(-32'sd3, 1'b0, 1'b0);
        add_beat(32'sd3,  1'b0, 1'b0);
        add_beat(-32'sd3, 1'b0, 1'b0);
        add_beat(32'sd3,  1'b1, 1'b0);
        // strictly descending, then strictly ascending
        for (int i = 4; i >= 0; i--)
            add_beat(ais_pkg::key_t'(i * 10), i == 0, 1'b0);
        for (int i = 0; i < 4; i++)
            add_beat(ais_pkg::key_t'(i * 7 - 10), i == 3, 1'b0);

        // a store filled exactly, then one given 1 to 4 values beyond its capacity
        add_set(CAPACITY, 1'b0);
        add_set(CAPACITY + $urandom_range(1, 4), 1'b1);
        queued = pending.size();
        while (queued < RANDOM_ITEMS) begin
            size = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                                : $urandom_range(1, 12);
            add_set(size, $urandom_range(0, 7) == 0);
            queued += size;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (order_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TAIL) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
